// ----- hdl/pinned_lru_byte_budget_cache_top_assert.svh -----
// Assertion macros for the cache block; clocked on clk, disabled in reset.
`ifndef PINNED_LRU_BYTE_BUDGET_CACHE_TOP_ASSERT_SVH
`define PINNED_LRU_BYTE_BUDGET_CACHE_TOP_ASSERT_SVH
`ifndef SYNTH
`define PLBC_AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plbc check failed");
`define PLBC_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plbc check failed");
`else
`define PLBC_AST_NOW(lbl, ante, cons)
`define PLBC_AST_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/plbc_pkg.sv -----
`default_nettype none
package plbc_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 16;
  localparam int SIZE_W       = 32;
  localparam int BYTES_W      = 40;
  localparam int STAT_W       = 32;
  localparam int REF_W        = 16;
  localparam int STAMP_W      = 32;
  localparam int KIND_W       = 3;
  localparam int CMD_W        = 2;
  localparam int APB_DW       = 64;
  localparam int APB_AW       = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_FLUSH   = 2'd2
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_EVICTED  = 3'd0,
    KIND_ACQUIRED = 3'd1,
    KIND_RELEASED = 3'd2,
    KIND_UNKNOWN  = 3'd3,
    KIND_ZERO     = 3'd4,
    KIND_FULL     = 3'd5,
    KIND_FLUSHED  = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_LOAD,
    ST_DRAIN
  } state_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_FLUSH,
    ACT_REL_MISS,
    ACT_REL,
    ACT_HIT,
    ACT_ZERO,
    ACT_EVICT,
    ACT_EVICT_SLOT,
    ACT_PICK_FREE,
    ACT_FULL,
    ACT_LOAD
  } act_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic scan_clear;
    logic scan_step;
    act_t act;
    logic pop;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic found;
    logic size_zero;
    logic over;
    logic victim_ok;
    logic free_ok;
    logic scan_last;
    logic fifo_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- hdl/plbc_ctrl.sv -----
`default_nettype none
module plbc_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire                 out_stall,
  input  plbc_pkg::dp_stat_t  stat,
  output plbc_pkg::ctrl_cmd_t cmd
);
  import plbc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd.capture    = 1'b0;
    cmd.scan_clear = 1'b0;
    cmd.scan_step  = 1'b0;
    cmd.act        = ACT_NONE;
    cmd.pop        = 1'b0;
    in_stall       = 1'b1;
    out_valid      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture    = 1'b1;
          cmd.scan_clear = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        unique case (stat.cmd)
          CMD_FLUSH: begin
            cmd.act   = ACT_FLUSH;
            state_nxt = ST_DRAIN;
          end
          CMD_RELEASE: begin
            cmd.act   = stat.found ? ACT_REL : ACT_REL_MISS;
            state_nxt = ST_DRAIN;
          end
          CMD_ACQUIRE: begin
            priority if (stat.found) begin
              cmd.act   = ACT_HIT;
              state_nxt = ST_DRAIN;
            end else if (stat.size_zero) begin
              cmd.act   = ACT_ZERO;
              state_nxt = ST_DRAIN;
            end else if (stat.over && stat.victim_ok) begin
              // evict for budget, then rescan the table
              cmd.act        = ACT_EVICT;
              cmd.scan_clear = 1'b1;
              state_nxt      = ST_SCAN;
            end else if (stat.free_ok) begin
              cmd.act   = ACT_PICK_FREE;
              state_nxt = ST_LOAD;
            end else if (stat.victim_ok) begin
              cmd.act   = ACT_EVICT_SLOT;
              state_nxt = ST_LOAD;
            end else begin
              cmd.act   = ACT_FULL;
              state_nxt = ST_DRAIN;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_LOAD: begin
        cmd.act   = ACT_LOAD;
        state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.pop = 1'b1;
          if (stat.fifo_last) state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/plbc_dp.sv -----
`default_nettype none
`include "pinned_lru_byte_budget_cache_top_assert.svh"
module plbc_dp #(
  parameter int ENTRIES  = plbc_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = plbc_pkg::KEY_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire  [plbc_pkg::CMD_W-1:0]           in_command,
  input  wire  [KEY_BITS-1:0]                  in_key,
  input  wire  [plbc_pkg::SIZE_W-1:0]          in_size_bytes,
  input  wire  [plbc_pkg::BYTES_W-1:0]         byte_budget,
  input  plbc_pkg::ctrl_cmd_t                  cmd,
  output plbc_pkg::dp_stat_t                   stat,
  output logic [plbc_pkg::KIND_W-1:0]          out_kind,
  output logic [KEY_BITS-1:0]                  out_item_key,
  output logic [$clog2(ENTRIES)-1:0]           out_slot,
  output logic [plbc_pkg::SIZE_W-1:0]          out_entry_bytes,
  output logic                                 out_cache_hit,
  output logic                                 out_over_budget,
  output logic                                 out_last,
  output logic [$clog2(ENTRIES+1)-1:0]         out_resident_count,
  output logic [plbc_pkg::BYTES_W-1:0]         out_resident_bytes,
  output logic [plbc_pkg::BYTES_W-1:0]         out_peak_bytes,
  output logic [plbc_pkg::STAT_W-1:0]          out_hit_count,
  output logic [plbc_pkg::STAT_W-1:0]          out_evict_count
);
  import plbc_pkg::*;

  localparam int IW    = $clog2(ENTRIES);
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int DEPTH = ENTRIES + 1;
  localparam int FW    = $clog2(DEPTH);
  localparam int PW    = $clog2(DEPTH + 1);

  // slot table
  logic                valid_r [ENTRIES];
  logic [KEY_BITS-1:0] skey_r  [ENTRIES];
  logic [SIZE_W-1:0]   sbytes_r[ENTRIES];
  logic [REF_W-1:0]    refs_r  [ENTRIES];
  logic [STAMP_W-1:0]  rstamp_r[ENTRIES];

  // item being worked on
  logic [CMD_W-1:0]    cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [SIZE_W-1:0]   size_r;

  // scan results
  logic [IW-1:0]       idx_r;
  logic                found_r, free_ok_r, vic_ok_r;
  logic [IW-1:0]       hit_slot_r, free_slot_r, vic_slot_r, tgt_r;
  logic [SIZE_W-1:0]   hit_bytes_r, vic_bytes_r;
  logic [REF_W-1:0]    hit_refs_r;
  logic [KEY_BITS-1:0] vic_key_r;
  logic [STAMP_W-1:0]  vic_age_r;
  logic                over_r;

  // totals and counters
  logic [CW-1:0]       cnt_r;
  logic [BYTES_W-1:0]  total_r, peak_r;
  logic [STAT_W-1:0]   hits_r, evicts_r;
  logic [STAMP_W-1:0]  stamp_ctr_r;

  // result queue
  logic [KIND_W-1:0]   f_kind_r [DEPTH];
  logic [KEY_BITS-1:0] f_key_r  [DEPTH];
  logic [IW-1:0]       f_slot_r [DEPTH];
  logic [SIZE_W-1:0]   f_bytes_r[DEPTH];
  logic                f_hit_r  [DEPTH];
  logic                f_over_r [DEPTH];
  logic [PW-1:0]       wr_r, rd_r;

  logic                cur_valid, cur_match, cur_unpinned;
  logic [STAMP_W-1:0]  cur_age;
  logic [BYTES_W:0]    need;
  logic                over;
  logic [BYTES_W-1:0]  tot_ld;
  logic                push;
  kind_t               p_kind;
  logic [KEY_BITS-1:0] p_key;
  logic [IW-1:0]       p_slot;
  logic [SIZE_W-1:0]   p_bytes;
  logic                p_hit, p_over;

  // one slot examined per scan cycle
  assign cur_valid    = valid_r[idx_r];
  assign cur_match    = cur_valid && (skey_r[idx_r] == key_r);
  assign cur_unpinned = cur_valid && (refs_r[idx_r] == '0);
  assign cur_age      = stamp_ctr_r - rstamp_r[idx_r];

  // budget check; zero budget disables it
  assign need   = {1'b0, total_r} + {{(BYTES_W - SIZE_W + 1){1'b0}}, size_r};
  assign over   = (byte_budget != '0) && (need > {1'b0, byte_budget});
  assign tot_ld = total_r + {{(BYTES_W - SIZE_W){1'b0}}, size_r};

  assign stat.cmd       = cmd_r;
  assign stat.found     = found_r;
  assign stat.size_zero = (size_r == '0);
  assign stat.over      = over;
  assign stat.victim_ok = vic_ok_r;
  assign stat.free_ok   = free_ok_r;
  assign stat.scan_last = (idx_r == IW'(ENTRIES - 1));
  assign stat.fifo_last = ((rd_r + PW'(1)) == wr_r);

  // record written to the result queue
  always_comb begin
    push    = 1'b1;
    p_kind  = KIND_ACQUIRED;
    p_key   = key_r;
    p_slot  = '0;
    p_bytes = '0;
    p_hit   = 1'b0;
    p_over  = 1'b0;
    unique case (cmd.act)
      ACT_FLUSH: begin
        p_kind = KIND_FLUSHED;
        p_key  = '0;
      end
      ACT_REL_MISS: p_kind = KIND_UNKNOWN;
      ACT_REL: begin
        p_kind  = KIND_RELEASED;
        p_slot  = hit_slot_r;
        p_bytes = hit_bytes_r;
      end
      ACT_HIT: begin
        p_slot  = hit_slot_r;
        p_bytes = hit_bytes_r;
        p_hit   = 1'b1;
      end
      ACT_ZERO: p_kind = KIND_ZERO;
      ACT_EVICT, ACT_EVICT_SLOT: begin
        p_kind  = KIND_EVICTED;
        p_key   = vic_key_r;
        p_slot  = vic_slot_r;
        p_bytes = vic_bytes_r;
      end
      ACT_FULL: p_kind = KIND_FULL;
      ACT_LOAD: begin
        p_slot  = tgt_r;
        p_bytes = size_r;
        p_over  = over_r;
      end
      default: push = 1'b0;
    endcase
  end

  // control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) valid_r[i] <= 1'b0;
      found_r     <= 1'b0;
      free_ok_r   <= 1'b0;
      vic_ok_r    <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
      total_r     <= '0;
      peak_r      <= '0;
      hits_r      <= '0;
      evicts_r    <= '0;
      stamp_ctr_r <= '0;
      wr_r        <= '0;
      rd_r        <= '0;
    end else begin
      if (cmd.capture) begin
        wr_r <= '0;
        rd_r <= '0;
      end else begin
        if (push) wr_r <= wr_r + PW'(1);
        if (cmd.pop) rd_r <= rd_r + PW'(1);
      end
      // scan bookkeeping
      if (cmd.scan_clear) begin
        idx_r     <= '0;
        found_r   <= 1'b0;
        free_ok_r <= 1'b0;
        vic_ok_r  <= 1'b0;
      end else if (cmd.scan_step) begin
        idx_r <= idx_r + IW'(1);
        if (cur_match && !found_r) found_r <= 1'b1;
        if (!cur_valid && !free_ok_r) free_ok_r <= 1'b1;
        if (cur_unpinned && (!vic_ok_r || cur_age > vic_age_r)) vic_ok_r <= 1'b1;
      end
      // table actions
      unique case (cmd.act)
        ACT_FLUSH: begin
          for (int i = 0; i < ENTRIES; i++) valid_r[i] <= 1'b0;
          cnt_r   <= '0;
          total_r <= '0;
        end
        ACT_REL: begin
          if (hit_refs_r == REF_W'(1)) stamp_ctr_r <= stamp_ctr_r + STAMP_W'(1);
        end
        ACT_HIT: hits_r <= hits_r + STAT_W'(1);
        ACT_EVICT, ACT_EVICT_SLOT: begin
          valid_r[vic_slot_r] <= 1'b0;
          cnt_r    <= cnt_r - CW'(1);
          total_r  <= total_r - {{(BYTES_W - SIZE_W){1'b0}}, vic_bytes_r};
          evicts_r <= evicts_r + STAT_W'(1);
        end
        ACT_LOAD: begin
          valid_r[tgt_r] <= 1'b1;
          cnt_r   <= cnt_r + CW'(1);
          total_r <= tot_ld;
          if (tot_ld > peak_r) peak_r <= tot_ld;
        end
        default: ;
      endcase
    end
  end

  // payload: table contents, captured item, scan picks, queue
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= in_command;
      key_r  <= in_key;
      size_r <= in_size_bytes;
    end
    if (cmd.scan_step) begin
      if (cur_match && !found_r) begin
        hit_slot_r  <= idx_r;
        hit_bytes_r <= sbytes_r[idx_r];
        hit_refs_r  <= refs_r[idx_r];
      end
      if (!cur_valid && !free_ok_r) free_slot_r <= idx_r;
      if (cur_unpinned && (!vic_ok_r || cur_age > vic_age_r)) begin
        vic_slot_r  <= idx_r;
        vic_key_r   <= skey_r[idx_r];
        vic_bytes_r <= sbytes_r[idx_r];
        vic_age_r   <= cur_age;
      end
    end
    unique case (cmd.act)
      ACT_REL: begin
        if (hit_refs_r != '0) refs_r[hit_slot_r] <= hit_refs_r - REF_W'(1);
        if (hit_refs_r == REF_W'(1)) rstamp_r[hit_slot_r] <= stamp_ctr_r;
      end
      ACT_HIT: begin
        if (hit_refs_r != '1) refs_r[hit_slot_r] <= hit_refs_r + REF_W'(1);
      end
      ACT_PICK_FREE: begin
        tgt_r  <= free_slot_r;
        over_r <= over;
      end
      ACT_EVICT_SLOT: begin
        tgt_r  <= vic_slot_r;
        over_r <= over;
      end
      ACT_LOAD: begin
        skey_r[tgt_r]   <= key_r;
        sbytes_r[tgt_r] <= size_r;
        refs_r[tgt_r]   <= REF_W'(1);
        rstamp_r[tgt_r] <= '0;
      end
      default: ;
    endcase
    if (push) begin
      f_kind_r[wr_r[FW-1:0]]  <= p_kind;
      f_key_r[wr_r[FW-1:0]]   <= p_key;
      f_slot_r[wr_r[FW-1:0]]  <= p_slot;
      f_bytes_r[wr_r[FW-1:0]] <= p_bytes;
      f_hit_r[wr_r[FW-1:0]]   <= p_hit;
      f_over_r[wr_r[FW-1:0]]  <= p_over;
    end
  end

  // result output; status is final while the queue drains
  assign out_kind           = f_kind_r[rd_r[FW-1:0]];
  assign out_item_key       = f_key_r[rd_r[FW-1:0]];
  assign out_slot           = f_slot_r[rd_r[FW-1:0]];
  assign out_entry_bytes    = f_bytes_r[rd_r[FW-1:0]];
  assign out_cache_hit      = f_hit_r[rd_r[FW-1:0]];
  assign out_over_budget    = f_over_r[rd_r[FW-1:0]];
  assign out_last           = stat.fifo_last;
  assign out_resident_count = cnt_r;
  assign out_resident_bytes = total_r;
  assign out_peak_bytes     = peak_r;
  assign out_hit_count      = hits_r;
  assign out_evict_count    = evicts_r;

  `PLBC_AST_NOW(a_cnt_range, 1'b1, cnt_r <= CW'(ENTRIES))
  `PLBC_AST_NOW(a_empty_bytes, cnt_r == '0, total_r == '0)
  `PLBC_AST_NEXT(a_flush_clears, cmd.act == ACT_FLUSH, cnt_r == '0 && total_r == '0)
  `PLBC_AST_NOW(a_queue_depth, 1'b1, wr_r <= PW'(DEPTH) && rd_r <= wr_r)

endmodule
`default_nettype wire

// ----- hdl/pinned_lru_byte_budget_cache_top.sv -----
`default_nettype none
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  in_command, in_key, in_size_bytes
// out      output     out_valid/out_stall kind, key, slot, bytes, flags, status
// cfg      input      APB psel/penable   byte_budget at address 0
//
// An item scans the table one slot a cycle, then decides; each budget eviction
// rescans the table, and a miss that gets a free or evicted slot takes a load step.
// Results are queued and sent after the item completes; one item at a time.
// Reset is synchronous, active low; the table comes up empty.
module pinned_lru_byte_budget_cache_top #(
  parameter int ENTRIES  = plbc_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = plbc_pkg::KEY_BITS_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  [plbc_pkg::CMD_W-1:0]    in_command,
  input  wire  [KEY_BITS-1:0]           in_key,
  input  wire  [plbc_pkg::SIZE_W-1:0]   in_size_bytes,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [plbc_pkg::KIND_W-1:0]   out_kind,
  output logic [KEY_BITS-1:0]           out_item_key,
  output logic [$clog2(ENTRIES)-1:0]    out_slot,
  output logic [plbc_pkg::SIZE_W-1:0]   out_entry_bytes,
  output logic                          out_cache_hit,
  output logic                          out_over_budget,
  output logic                          out_last,
  output logic [$clog2(ENTRIES+1)-1:0]  out_resident_count,
  output logic [plbc_pkg::BYTES_W-1:0]  out_resident_bytes,
  output logic [plbc_pkg::BYTES_W-1:0]  out_peak_bytes,
  output logic [plbc_pkg::STAT_W-1:0]   out_hit_count,
  output logic [plbc_pkg::STAT_W-1:0]   out_evict_count,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [plbc_pkg::APB_AW-1:0]   paddr,
  input  wire  [plbc_pkg::APB_DW-1:0]   pwdata,
  output logic [plbc_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import plbc_pkg::*;

  logic [BYTES_W-1:0] budget_r;
  logic               sel_budget;
  ctrl_cmd_t          cmd;
  dp_stat_t           stat;

  // register decode: one 40-bit register, read as 64 bits, at byte addresses 0 to 7
  assign sel_budget = (paddr[APB_AW-1] == 1'b0);
  assign pready     = 1'b1;
  assign prdata     = sel_budget ? {{(APB_DW - BYTES_W){1'b0}}, budget_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= '0;
    end else if (psel && penable && pwrite && sel_budget) begin
      budget_r <= pwdata[BYTES_W-1:0];
    end
  end

  plbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  plbc_dp #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_command         (in_command),
    .in_key             (in_key),
    .in_size_bytes      (in_size_bytes),
    .byte_budget        (budget_r),
    .cmd                (cmd),
    .stat               (stat),
    .out_kind           (out_kind),
    .out_item_key       (out_item_key),
    .out_slot           (out_slot),
    .out_entry_bytes    (out_entry_bytes),
    .out_cache_hit      (out_cache_hit),
    .out_over_budget    (out_over_budget),
    .out_last           (out_last),
    .out_resident_count (out_resident_count),
    .out_resident_bytes (out_resident_bytes),
    .out_peak_bytes     (out_peak_bytes),
    .out_hit_count      (out_hit_count),
    .out_evict_count    (out_evict_count)
  );

endmodule
`default_nettype wire
